[design/sip_pkg.sv]
// Shared widths, types and helpers for the segment intersection point pipeline
`default_nettype none

package sip_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int TOL_BITS   = 16;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int MUL_W    = 2 * COORD_BITS;
    localparam int DET_W    = PROD_W + 1;
    localparam int CR_W     = MUL_W + 1;
    localparam int CR_LO_W  = CR_W / 2;
    localparam int CR_HI_W  = CR_W - CR_LO_W;
    localparam int LO_W     = DIFF_W + CR_LO_W + 1;
    localparam int HI_W     = DIFF_W + CR_HI_W;
    localparam int NUM_W    = DIFF_W + CR_W + 1;
    localparam int QW       = COORD_BITS;
    localparam int SQ_W     = COORD_BITS + 2;
    localparam int SQ_N_W   = 2 * SQ_W;
    localparam int NEAR_W   = (DIFF_W > TOL_BITS) ? DIFF_W : TOL_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic        [TOL_BITS-1:0]   tol_t;

    localparam tol_t TOL_RESET = tol_t'(26);

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
        coord_t x4;
        coord_t y4;
    } seg_pts_t;

    typedef struct packed {
        seg_pts_t pts;
        logic     s3;
        logic     s4;
        logic     e3;
        logic     e4;
    } seg_ctx_t;

    typedef struct packed {
        logic             ident;
        logic             par;
        logic             negx;
        logic             negy;
        logic [NUM_W-1:0] nmx;
        logic [NUM_W-1:0] nmy;
        logic [DET_W-1:0] dm;
    } fd_t;

    typedef struct packed {
        logic   ident;
        logic   par;
        logic   fitx;
        logic   fity;
        coord_t qx;
        coord_t qy;
    } dr_t;

    function automatic logic near_pt(input coord_t a, input coord_t b, input tol_t t);
        diff_t             d;
        logic [DIFF_W-1:0] m;
        d = diff_t'(a) - diff_t'(b);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return NEAR_W'(m) < NEAR_W'(t);
    endfunction

endpackage

`default_nettype wire

[design/sip_front.sv]
// Front end: endpoint match flags, determinant, cross products and numerators
`default_nettype none

module sip_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  sip_pkg::tol_t     tol,
    input  logic              in_valid,
    input  sip_pkg::seg_pts_t in_pts,
    output logic              out_valid,
    output sip_pkg::seg_ctx_t out_ctx,
    output sip_pkg::fd_t      out_fd
);
    import sip_pkg::*;

    logic [6:0] v_reg;
    seg_ctx_t   ctx_reg [1:7];

    diff_t d12x_reg [1:3];
    diff_t d12y_reg [1:3];
    diff_t d34x_reg [1:3];
    diff_t d34y_reg [1:3];

    logic signed [PROD_W-1:0] pa_reg;
    logic signed [PROD_W-1:0] pb_reg;
    logic signed [MUL_W-1:0]  m34a_reg;
    logic signed [MUL_W-1:0]  m34b_reg;
    logic signed [MUL_W-1:0]  m12a_reg;
    logic signed [MUL_W-1:0]  m12b_reg;

    logic signed [DET_W-1:0] det3_reg;
    logic signed [CR_W-1:0]  c34_reg;
    logic signed [CR_W-1:0]  c12_reg;

    logic signed [LO_W-1:0] axl_reg, bxl_reg, ayl_reg, byl_reg;
    logic signed [HI_W-1:0] axh_reg, bxh_reg, ayh_reg, byh_reg;
    logic        [DET_W-1:0] dm_reg [4:6];
    logic                    dneg_reg [4:6];

    logic signed [NUM_W-1:0] tax_reg, tbx_reg, tay_reg, tby_reg;
    logic                    par_reg [5:6];
    logic signed [NUM_W-1:0] nx_reg, ny_reg;

    fd_t fd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[1].pts <= in_pts;
            ctx_reg[1].s3  <= near_pt(in_pts.x1, in_pts.x3, tol) &&
                              near_pt(in_pts.y1, in_pts.y3, tol);
            ctx_reg[1].s4  <= near_pt(in_pts.x1, in_pts.x4, tol) &&
                              near_pt(in_pts.y1, in_pts.y4, tol);
            ctx_reg[1].e3  <= near_pt(in_pts.x2, in_pts.x3, tol) &&
                              near_pt(in_pts.y2, in_pts.y3, tol);
            ctx_reg[1].e4  <= near_pt(in_pts.x2, in_pts.x4, tol) &&
                              near_pt(in_pts.y2, in_pts.y4, tol);
            d12x_reg[1] <= diff_t'(in_pts.x1) - diff_t'(in_pts.x2);
            d12y_reg[1] <= diff_t'(in_pts.y1) - diff_t'(in_pts.y2);
            d34x_reg[1] <= diff_t'(in_pts.x3) - diff_t'(in_pts.x4);
            d34y_reg[1] <= diff_t'(in_pts.y3) - diff_t'(in_pts.y4);
            for (int k = 2; k <= 7; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            for (int k = 2; k <= 3; k++)
            begin
                d12x_reg[k] <= d12x_reg[k-1];
                d12y_reg[k] <= d12y_reg[k-1];
                d34x_reg[k] <= d34x_reg[k-1];
                d34y_reg[k] <= d34y_reg[k-1];
            end

            pa_reg   <= PROD_W'(d34x_reg[1]) * PROD_W'(d12y_reg[1]);
            pb_reg   <= PROD_W'(d12x_reg[1]) * PROD_W'(d34y_reg[1]);
            m34a_reg <= MUL_W'(ctx_reg[1].pts.x3) * MUL_W'(ctx_reg[1].pts.y4);
            m34b_reg <= MUL_W'(ctx_reg[1].pts.x4) * MUL_W'(ctx_reg[1].pts.y3);
            m12a_reg <= MUL_W'(ctx_reg[1].pts.x1) * MUL_W'(ctx_reg[1].pts.y2);
            m12b_reg <= MUL_W'(ctx_reg[1].pts.x2) * MUL_W'(ctx_reg[1].pts.y1);

            det3_reg <= DET_W'(pa_reg) - DET_W'(pb_reg);
            c34_reg  <= CR_W'(m34a_reg) - CR_W'(m34b_reg);
            c12_reg  <= CR_W'(m12a_reg) - CR_W'(m12b_reg);

            axl_reg <= LO_W'(d12x_reg[3]) * LO_W'($signed({1'b0, c34_reg[CR_LO_W-1:0]}));
            axh_reg <= HI_W'(d12x_reg[3]) * HI_W'($signed(c34_reg[CR_W-1:CR_LO_W]));
            bxl_reg <= LO_W'(d34x_reg[3]) * LO_W'($signed({1'b0, c12_reg[CR_LO_W-1:0]}));
            bxh_reg <= HI_W'(d34x_reg[3]) * HI_W'($signed(c12_reg[CR_W-1:CR_LO_W]));
            ayl_reg <= LO_W'(d12y_reg[3]) * LO_W'($signed({1'b0, c34_reg[CR_LO_W-1:0]}));
            ayh_reg <= HI_W'(d12y_reg[3]) * HI_W'($signed(c34_reg[CR_W-1:CR_LO_W]));
            byl_reg <= LO_W'(d34y_reg[3]) * LO_W'($signed({1'b0, c12_reg[CR_LO_W-1:0]}));
            byh_reg <= HI_W'(d34y_reg[3]) * HI_W'($signed(c12_reg[CR_W-1:CR_LO_W]));
            dm_reg[4]   <= det3_reg[DET_W-1] ? DET_W'(-det3_reg) : DET_W'(det3_reg);
            dneg_reg[4] <= det3_reg[DET_W-1];

            tax_reg <= (NUM_W'(axh_reg) <<< CR_LO_W) + NUM_W'(axl_reg);
            tbx_reg <= (NUM_W'(bxh_reg) <<< CR_LO_W) + NUM_W'(bxl_reg);
            tay_reg <= (NUM_W'(ayh_reg) <<< CR_LO_W) + NUM_W'(ayl_reg);
            tby_reg <= (NUM_W'(byh_reg) <<< CR_LO_W) + NUM_W'(byl_reg);
            par_reg[5]  <= (dm_reg[4] == '0) ||
                           (dm_reg[4] < (DET_W'(tol) << FRAC_BITS));
            dm_reg[5]   <= dm_reg[4];
            dneg_reg[5] <= dneg_reg[4];

            nx_reg      <= tax_reg - tbx_reg;
            ny_reg      <= tay_reg - tby_reg;
            par_reg[6]  <= par_reg[5];
            dm_reg[6]   <= dm_reg[5];
            dneg_reg[6] <= dneg_reg[5];

            fd_reg.ident <= (ctx_reg[6].s3 && ctx_reg[6].e4) ||
                            (ctx_reg[6].s4 && ctx_reg[6].e3);
            fd_reg.par   <= par_reg[6];
            fd_reg.negx  <= nx_reg[NUM_W-1] ^ dneg_reg[6];
            fd_reg.negy  <= ny_reg[NUM_W-1] ^ dneg_reg[6];
            fd_reg.nmx   <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            fd_reg.nmy   <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            fd_reg.dm    <= dm_reg[6];
        end
    end

    assign out_valid = v_reg[6];
    assign out_ctx   = ctx_reg[7];
    assign out_fd    = fd_reg;

endmodule

`default_nettype wire

[design/sip_div.sv]
// Pipelined restoring divider, one quotient bit per stage for both coordinates
`default_nettype none

module sip_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  sip_pkg::seg_ctx_t in_ctx,
    input  sip_pkg::fd_t      in_fd,
    output logic              out_valid,
    output sip_pkg::seg_ctx_t out_ctx,
    output sip_pkg::dr_t      out_dr
);
    import sip_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] rx;
        logic [NUM_W-1:0] ry;
        logic [QW-1:0]    qx;
        logic [QW-1:0]    qy;
        logic [DET_W-1:0] dm;
        logic             ovx;
        logic             ovy;
        logic             negx;
        logic             negy;
        logic             ident;
        logic             par;
    } div_st_t;

    logic [QW+1:0] v_reg;
    seg_ctx_t      ctx_reg [0:QW+1];
    div_st_t       st_reg  [0:QW];
    dr_t           dr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0]      <= in_ctx;
            st_reg[0].rx    <= in_fd.nmx;
            st_reg[0].ry    <= in_fd.nmy;
            st_reg[0].qx    <= '0;
            st_reg[0].qy    <= '0;
            st_reg[0].dm    <= in_fd.dm;
            st_reg[0].ovx   <= (NUM_W+1)'(in_fd.nmx) >= ((NUM_W+1)'(in_fd.dm) << QW);
            st_reg[0].ovy   <= (NUM_W+1)'(in_fd.nmy) >= ((NUM_W+1)'(in_fd.dm) << QW);
            st_reg[0].negx  <= in_fd.negx;
            st_reg[0].negy  <= in_fd.negy;
            st_reg[0].ident <= in_fd.ident;
            st_reg[0].par   <= in_fd.par;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int B = QW - k;
        logic [NUM_W-1:0] sh;
        div_st_t          st_next;

        always_comb
        begin
            sh      = NUM_W'(st_reg[k-1].dm) << B;
            st_next = st_reg[k-1];
            if (st_reg[k-1].rx >= sh)
            begin
                st_next.rx    = st_reg[k-1].rx - sh;
                st_next.qx[B] = 1'b1;
            end
            if (st_reg[k-1].ry >= sh)
            begin
                st_next.ry    = st_reg[k-1].ry - sh;
                st_next.qy[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                st_reg[k]  <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[QW+1] <= ctx_reg[QW];
            dr_reg.ident  <= st_reg[QW].ident;
            dr_reg.par    <= st_reg[QW].par;
            dr_reg.fitx   <= !st_reg[QW].ovx && (!st_reg[QW].qx[QW-1] ||
                             (st_reg[QW].negx && (st_reg[QW].qx[QW-2:0] == '0)));
            dr_reg.fity   <= !st_reg[QW].ovy && (!st_reg[QW].qy[QW-1] ||
                             (st_reg[QW].negy && (st_reg[QW].qy[QW-2:0] == '0)));
            dr_reg.qx     <= st_reg[QW].negx ? coord_t'(-st_reg[QW].qx) :
                                               coord_t'(st_reg[QW].qx);
            dr_reg.qy     <= st_reg[QW].negy ? coord_t'(-st_reg[QW].qy) :
                                               coord_t'(st_reg[QW].qy);
        end
    end

    assign out_valid = v_reg[QW+1];
    assign out_ctx   = ctx_reg[QW+1];
    assign out_dr    = dr_reg;

endmodule

`default_nettype wire

[design/sip_dist.sv]
// Distance lanes with pipelined square roots, on-segment tests and result select
`default_nettype none

module sip_dist
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  sip_pkg::tol_t     tol,
    input  logic              in_valid,
    input  sip_pkg::seg_ctx_t in_ctx,
    input  sip_pkg::dr_t      in_dr,
    output logic              out_valid,
    output logic              crosses,
    output sip_pkg::coord_t   cross_x,
    output sip_pkg::coord_t   cross_y
);
    import sip_pkg::*;

    localparam int NL   = 6;
    localparam int TR_W = SQ_N_W + 1;
    localparam int SN_W = SQ_W + 2;
    localparam int LAST = SQ_W + 4;

    typedef struct packed {
        seg_ctx_t                     ctx;
        dr_t                          dr;
        logic [3:0]                   sq;
        logic [NL-1:0][SQ_N_W-1:0]    rem;
        logic [NL-1:0][SQ_W-1:0]      root;
    } sq_st_t;

    function automatic logic [DIFF_W-1:0] absdiff(input coord_t a, input coord_t b);
        diff_t d;
        d = diff_t'(a) - diff_t'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    function automatic logic near_len(input logic [SQ_W:0] s, input logic [SQ_W-1:0] d,
                                      input tol_t t);
        logic signed [SN_W-1:0] e;
        logic        [SN_W-1:0] m;
        e = $signed(SN_W'(s)) - $signed(SN_W'(d));
        m = e[SN_W-1] ? SN_W'(-e) : SN_W'(e);
        return ((SN_W > TOL_BITS) ? (m < SN_W'(t)) : (TOL_BITS'(m) < t));
    endfunction

    logic [LAST:0] v_reg;

    coord_t ux [NL];
    coord_t uy [NL];
    coord_t wx [NL];
    coord_t wy [NL];

    seg_ctx_t                  a_ctx_reg, b_ctx_reg;
    dr_t                       a_dr_reg, b_dr_reg;
    logic [3:0]                a_sq_reg, b_sq_reg;
    logic [NL-1:0][DIFF_W-1:0] a_mx_reg, a_my_reg;
    logic [NL-1:0][PROD_W-1:0] b_px_reg, b_py_reg;
    sq_st_t                    sq_reg [0:SQ_W];

    seg_ctx_t d_ctx_reg;
    dr_t      d_dr_reg;
    logic     d_on1_reg;
    logic     d_on2_reg;

    logic   cr_reg;
    coord_t cx_reg;
    coord_t cy_reg;
    logic   cr_next;
    coord_t cx_next;
    coord_t cy_next;

    always_comb
    begin
        ux[0] = in_dr.qx;          uy[0] = in_dr.qy;
        wx[0] = in_ctx.pts.x1;     wy[0] = in_ctx.pts.y1;
        ux[1] = in_dr.qx;          uy[1] = in_dr.qy;
        wx[1] = in_ctx.pts.x2;     wy[1] = in_ctx.pts.y2;
        ux[2] = in_ctx.pts.x1;     uy[2] = in_ctx.pts.y1;
        wx[2] = in_ctx.pts.x2;     wy[2] = in_ctx.pts.y2;
        ux[3] = in_dr.qx;          uy[3] = in_dr.qy;
        wx[3] = in_ctx.pts.x3;     wy[3] = in_ctx.pts.y3;
        ux[4] = in_dr.qx;          uy[4] = in_dr.qy;
        wx[4] = in_ctx.pts.x4;     wy[4] = in_ctx.pts.y4;
        ux[5] = in_ctx.pts.x3;     uy[5] = in_ctx.pts.y3;
        wx[5] = in_ctx.pts.x4;     wy[5] = in_ctx.pts.y4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctx_reg <= in_ctx;
            a_dr_reg  <= in_dr;
            for (int j = 0; j < 4; j++)
            begin
                a_sq_reg[j] <= near_pt(in_dr.qx, wx[j < 2 ? j : j + 1], tol) &&
                               near_pt(in_dr.qy, wy[j < 2 ? j : j + 1], tol);
            end
            for (int j = 0; j < NL; j++)
            begin
                a_mx_reg[j] <= absdiff(ux[j], wx[j]);
                a_my_reg[j] <= absdiff(uy[j], wy[j]);
            end

            b_ctx_reg <= a_ctx_reg;
            b_dr_reg  <= a_dr_reg;
            b_sq_reg  <= a_sq_reg;
            for (int j = 0; j < NL; j++)
            begin
                b_px_reg[j] <= PROD_W'(a_mx_reg[j]) * PROD_W'(a_mx_reg[j]);
                b_py_reg[j] <= PROD_W'(a_my_reg[j]) * PROD_W'(a_my_reg[j]);
            end

            sq_reg[0].ctx <= b_ctx_reg;
            sq_reg[0].dr  <= b_dr_reg;
            sq_reg[0].sq  <= b_sq_reg;
            for (int j = 0; j < NL; j++)
            begin
                sq_reg[0].rem[j]  <= SQ_N_W'(b_px_reg[j]) + SQ_N_W'(b_py_reg[j]);
                sq_reg[0].root[j] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= SQ_W; k++)
    begin : g_root
        localparam int B = SQ_W - k;
        logic [NL-1:0][TR_W-1:0] trial;
        sq_st_t                  sq_next;

        always_comb
        begin
            sq_next = sq_reg[k-1];
            for (int j = 0; j < NL; j++)
            begin
                trial[j] = (TR_W'(sq_reg[k-1].root[j]) << (B + 1)) |
                           (TR_W'(1) << (2 * B));
                if (TR_W'(sq_reg[k-1].rem[j]) >= trial[j])
                begin
                    sq_next.rem[j]     = sq_reg[k-1].rem[j] - SQ_N_W'(trial[j]);
                    sq_next.root[j][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k] <= sq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctx_reg <= sq_reg[SQ_W].ctx;
            d_dr_reg  <= sq_reg[SQ_W].dr;
            d_on1_reg <= sq_reg[SQ_W].sq[0] || sq_reg[SQ_W].sq[1] ||
                         near_len((SQ_W+1)'(sq_reg[SQ_W].root[0]) +
                                  (SQ_W+1)'(sq_reg[SQ_W].root[1]),
                                  sq_reg[SQ_W].root[2], tol);
            d_on2_reg <= sq_reg[SQ_W].sq[2] || sq_reg[SQ_W].sq[3] ||
                         near_len((SQ_W+1)'(sq_reg[SQ_W].root[3]) +
                                  (SQ_W+1)'(sq_reg[SQ_W].root[4]),
                                  sq_reg[SQ_W].root[5], tol);
        end
    end

    always_comb
    begin
        if (d_dr_reg.ident)
        begin
            cr_next = 1'b0;
        end
        else if (d_dr_reg.par)
        begin
            cr_next = d_ctx_reg.s3 || d_ctx_reg.s4 || d_ctx_reg.e3 || d_ctx_reg.e4;
        end
        else
        begin
            cr_next = d_dr_reg.fitx && d_dr_reg.fity && d_on1_reg && d_on2_reg;
        end

        if (!cr_next)
        begin
            cx_next = '0;
            cy_next = '0;
        end
        else if (d_ctx_reg.s3 || d_ctx_reg.s4)
        begin
            cx_next = d_ctx_reg.pts.x1;
            cy_next = d_ctx_reg.pts.y1;
        end
        else if (d_ctx_reg.e3 || d_ctx_reg.e4)
        begin
            cx_next = d_ctx_reg.pts.x2;
            cy_next = d_ctx_reg.pts.y2;
        end
        else
        begin
            cx_next = d_dr_reg.qx;
            cy_next = d_dr_reg.qy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg <= cr_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    assign out_valid = v_reg[LAST];
    assign crosses   = cr_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;

endmodule

`default_nettype wire

[design/segment_intersection_point_top.sv]
// Top level of the segment intersection point pipeline
//
//   channel   signals                                   width per field
//   segment   seg_valid, seg_stall, eight coordinates   24 bits signed
//   result    res_valid, res_stall, crosses, x, y       1 / 24 / 24 bits
//   config    cfg_we, cfg_wdata (tolerance)             16 bits
//
// One segment pair per cycle while seg_stall is low.
// The pipeline includes the 24 quotient-bit divider stages and the 26 root-bit stages.
// Reset clears the stage valid bits and loads the tolerance with 26 (0.1).
// A held result freezes every stage; seg_stall is high exactly while it is held.
`default_nettype none

module segment_intersection_point_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  sip_pkg::tol_t   cfg_wdata,
    input  logic            seg_valid,
    output logic            seg_stall,
    input  sip_pkg::coord_t first_start_x,
    input  sip_pkg::coord_t first_start_y,
    input  sip_pkg::coord_t first_end_x,
    input  sip_pkg::coord_t first_end_y,
    input  sip_pkg::coord_t second_start_x,
    input  sip_pkg::coord_t second_start_y,
    input  sip_pkg::coord_t second_end_x,
    input  sip_pkg::coord_t second_end_y,
    output logic            res_valid,
    input  logic            res_stall,
    output logic            crosses,
    output sip_pkg::coord_t cross_x,
    output sip_pkg::coord_t cross_y
);
    import sip_pkg::*;

    tol_t     tol_reg;
    logic     en;
    seg_pts_t pts;
    logic     f_valid;
    seg_ctx_t f_ctx;
    fd_t      f_fd;
    logic     d_valid;
    seg_ctx_t d_ctx;
    dr_t      d_dr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    assign en        = !(res_valid && res_stall);
    assign seg_stall = !en;

    assign pts.x1 = first_start_x;
    assign pts.y1 = first_start_y;
    assign pts.x2 = first_end_x;
    assign pts.y2 = first_end_y;
    assign pts.x3 = second_start_x;
    assign pts.y3 = second_start_y;
    assign pts.x4 = second_end_x;
    assign pts.y4 = second_end_y;

    sip_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .in_valid  (seg_valid),
        .in_pts    (pts),
        .out_valid (f_valid),
        .out_ctx   (f_ctx),
        .out_fd    (f_fd)
    );

    sip_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_ctx    (f_ctx),
        .in_fd     (f_fd),
        .out_valid (d_valid),
        .out_ctx   (d_ctx),
        .out_dr    (d_dr)
    );

    sip_dist u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .in_valid  (d_valid),
        .in_ctx    (d_ctx),
        .in_dr     (d_dr),
        .out_valid (res_valid),
        .crosses   (crosses),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

endmodule

`default_nettype wire

[design/sip_checker.sv]
// Port-level checks for the segment intersection point top level
`default_nettype none

module sip_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            seg_stall,
    input logic            res_valid,
    input logic            res_stall,
    input logic            crosses,
    input sip_pkg::coord_t cross_x,
    input sip_pkg::coord_t cross_y
);
    import sip_pkg::*;

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(crosses) &&
                                   $stable(cross_x) && $stable(cross_y))
        else $error("result beat changed while stalled");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !crosses |-> (cross_x == '0) && (cross_y == '0))
        else $error("point not zero without crossing");

    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall == (res_valid && res_stall))
        else $error("input stall does not follow held result");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind segment_intersection_point_top sip_checker u_sip_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_stall (seg_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .crosses   (crosses),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
);

`default_nettype wire
